[src/bpprt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bpprt_pkg;

  localparam int unsigned LevelW   = 11;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned AngleW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [LevelW-1:0] FullScale = LevelW'(1024);
  localparam logic [AngleW-1:0] MaxAngle  = AngleW'(180);
  localparam logic [TicksW-1:0] TicksMax  = '1;

  typedef enum logic [1:0] {
    OP_LEFT  = 2'd0,
    OP_RIGHT = 2'd1,
    OP_PARK  = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESS_THR   = 3'd0,
    REG_RELEASE_THR = 3'd1,
    REG_PARK_THR    = 3'd2,
    REG_PULSE_TICKS = 3'd3,
    REG_RELEASE_POS = 3'd4,
    REG_HOME_POS    = 3'd5
  } reg_idx_e;

  localparam logic [LevelW-1:0] PressThrRst   = LevelW'(922);
  localparam logic [LevelW-1:0] ReleaseThrRst = LevelW'(717);
  localparam logic [LevelW-1:0] ParkThrRst    = LevelW'(922);
  localparam logic [TicksW-1:0] PulseTicksRst = TicksW'(400);
  localparam logic [AngleW-1:0] ReleasePosRst = AngleW'(0);
  localparam logic [AngleW-1:0] HomePosRst    = AngleW'(90);

  typedef struct packed {
    logic [LevelW-1:0] press_thr;
    logic [LevelW-1:0] release_thr;
    logic [LevelW-1:0] park_thr;
    logic [TicksW-1:0] pulse_ticks;
    logic [AngleW-1:0] release_pos;
    logic [AngleW-1:0] home_pos;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [LevelW-1:0] level;
  } item_t;

  typedef struct packed {
    logic              servo_write;
    logic [AngleW-1:0] servo_angle;
    logic              pedals_pressed;
    logic              release_armed;
    logic              pulse_active;
  } res_t;

  function automatic logic [LevelW-1:0] clamp_level(input logic [LevelW-1:0] v);
    return (v > FullScale) ? FullScale : v;
  endfunction

  function automatic logic [AngleW-1:0] clamp_angle(input logic [AngleW-1:0] a);
    return (a > MaxAngle) ? MaxAngle : a;
  endfunction

endpackage

`default_nettype wire

[src/bpprt_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bpprt_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     op;
  logic [bpprt_pkg::LevelW-1:0]   level;

  modport source (output valid, output op, output level, input ready);
  modport sink   (input valid, input op, input level, output ready);
endinterface

interface bpprt_out_if;
  logic                           valid;
  logic                           ready;
  logic                           servo_write;
  logic [bpprt_pkg::AngleW-1:0]   servo_angle;
  logic                           pedals_pressed;
  logic                           release_armed;
  logic                           pulse_active;

  modport source (output valid, output servo_write, output servo_angle,
                  output pedals_pressed, output release_armed, output pulse_active,
                  input ready);
  modport sink   (input valid, input servo_write, input servo_angle,
                  input pedals_pressed, input release_armed, input pulse_active,
                  output ready);
endinterface

`default_nettype wire

[src/brake_pedal_park_release_trigger_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Brake pedal park release trigger. Each transfer on in_i carries one item:
// a left pedal, right pedal or parking brake sample (levels 1024 = 1.0,
// clamped above that) or a millisecond tick, and yields exactly one result
// transfer on out_o with the servo command and the pressed, armed and pulse
// flags after the update. The unit takes one item per cycle while out_o is
// not stalled. Each item passes through an input register, then the flag
// update into the result register, before its result shows on out_o. The
// input side keeps accepting while a result waits on a stalled output, as
// long as the input register is free. Thresholds, pulse length and the two
// servo angles are written through cfg_we_i/cfg_idx_i/cfg_data_i; the
// user must write them only while the unit is idle (not enforced here).
// Unmapped indexes are ignored. Angles above 180 are saturated at use.
module brake_pedal_park_release_trigger_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bpprt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [bpprt_pkg::CfgDataW-1:0]   cfg_data_i,
  bpprt_in_if.sink                              in_i,
  bpprt_out_if.source                           out_o
);

  bpprt_pkg::cfg_t  cfg;
  bpprt_pkg::item_t item_q;
  bpprt_pkg::res_t  res;
  logic             in_vld_q;
  logic             out_vld_q;
  logic             advance;
  logic             in_take;

  bpprt_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // Advance the held item into the result register when that register is
  // empty or its result is being transferred this cycle.
  assign advance = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_take = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Hold the item payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.op    <= in_i.op;
      item_q.level <= in_i.level;
    end
  end

  bpprt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .item_i (item_q),
    .res_o  (res)
  );

  assign out_o.valid          = out_vld_q;
  assign out_o.servo_write    = res.servo_write;
  assign out_o.servo_angle    = res.servo_angle;
  assign out_o.pedals_pressed = res.pedals_pressed;
  assign out_o.release_armed  = res.release_armed;
  assign out_o.pulse_active   = res.pulse_active;

endmodule

`default_nettype wire

[src/bpprt_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpprt_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             we_i,
  input  wire logic [bpprt_pkg::CfgIdxW-1:0]    idx_i,
  input  wire logic [bpprt_pkg::CfgDataW-1:0]   data_i,
  output bpprt_pkg::cfg_t                       cfg_o
);

  bpprt_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_thr   <= bpprt_pkg::PressThrRst;
      cfg_q.release_thr <= bpprt_pkg::ReleaseThrRst;
      cfg_q.park_thr    <= bpprt_pkg::ParkThrRst;
      cfg_q.pulse_ticks <= bpprt_pkg::PulseTicksRst;
      cfg_q.release_pos <= bpprt_pkg::ReleasePosRst;
      cfg_q.home_pos    <= bpprt_pkg::HomePosRst;
    end else if (we_i) begin
      unique case (idx_i)
        bpprt_pkg::REG_PRESS_THR:   cfg_q.press_thr   <= data_i[bpprt_pkg::LevelW-1:0];
        bpprt_pkg::REG_RELEASE_THR: cfg_q.release_thr <= data_i[bpprt_pkg::LevelW-1:0];
        bpprt_pkg::REG_PARK_THR:    cfg_q.park_thr    <= data_i[bpprt_pkg::LevelW-1:0];
        bpprt_pkg::REG_PULSE_TICKS: cfg_q.pulse_ticks <= data_i[bpprt_pkg::TicksW-1:0];
        bpprt_pkg::REG_RELEASE_POS: cfg_q.release_pos <= data_i[bpprt_pkg::AngleW-1:0];
        bpprt_pkg::REG_HOME_POS:    cfg_q.home_pos    <= data_i[bpprt_pkg::AngleW-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[src/bpprt_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpprt_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire bpprt_pkg::cfg_t cfg_i,
  input  wire logic            step_i,
  input  wire bpprt_pkg::item_t item_i,
  output bpprt_pkg::res_t      res_o
);

  logic [bpprt_pkg::LevelW-1:0] left_q, left_d;
  logic [bpprt_pkg::LevelW-1:0] right_q, right_d;
  logic                         pressed_q, pressed_d;
  logic                         park_q, park_d;
  logic                         armed_q, armed_d;
  logic                         pulse_q, pulse_d;
  logic [bpprt_pkg::TicksW-1:0] elapsed_q, elapsed_d;
  bpprt_pkg::res_t              res_q, res_d;

  logic [bpprt_pkg::LevelW-1:0] lvl;
  logic [bpprt_pkg::LevelW-1:0] l_new, r_new;
  logic                         now_pressed;
  logic [bpprt_pkg::TicksW-1:0] elapsed_inc;

  always_comb begin
    lvl   = bpprt_pkg::clamp_level(item_i.level);
    l_new = (bpprt_pkg::op_e'(item_i.op) == bpprt_pkg::OP_LEFT)  ? lvl : left_q;
    r_new = (bpprt_pkg::op_e'(item_i.op) == bpprt_pkg::OP_RIGHT) ? lvl : right_q;
    // hysteresis: enter at press threshold, leave only when both drop below release
    if (pressed_q) begin
      now_pressed = !((l_new < cfg_i.release_thr) && (r_new < cfg_i.release_thr));
    end else begin
      now_pressed = (l_new >= cfg_i.press_thr) && (r_new >= cfg_i.press_thr);
    end
    elapsed_inc = (elapsed_q == bpprt_pkg::TicksMax) ? elapsed_q
                                                     : elapsed_q + bpprt_pkg::TicksW'(1);

    left_d    = l_new;
    right_d   = r_new;
    pressed_d = pressed_q;
    park_d    = park_q;
    armed_d   = armed_q;
    pulse_d   = pulse_q;
    elapsed_d = elapsed_q;
    res_d.servo_write = 1'b0;
    res_d.servo_angle = '0;

    unique case (bpprt_pkg::op_e'(item_i.op))
      bpprt_pkg::OP_LEFT, bpprt_pkg::OP_RIGHT: begin
        pressed_d = now_pressed;
        if (now_pressed && !pressed_q && park_q && armed_q) begin
          res_d.servo_write = 1'b1;
          res_d.servo_angle = bpprt_pkg::clamp_angle(cfg_i.release_pos);
          pulse_d   = 1'b1;
          elapsed_d = '0;
          armed_d   = 1'b0;
        end
        if (!now_pressed && pressed_q && park_q) begin
          armed_d = 1'b1;
        end
      end
      bpprt_pkg::OP_PARK: begin
        park_d = (lvl >= cfg_i.park_thr);
        if (!park_d || pressed_q) begin
          armed_d = 1'b0;
        end
      end
      bpprt_pkg::OP_TICK: begin
        if (pulse_q) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= cfg_i.pulse_ticks) begin
            res_d.servo_write = 1'b1;
            res_d.servo_angle = bpprt_pkg::clamp_angle(cfg_i.home_pos);
            pulse_d = 1'b0;
          end
        end
      end
      default: ;
    endcase

    res_d.pedals_pressed = pressed_d;
    res_d.release_armed  = armed_d;
    res_d.pulse_active   = pulse_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= '0;
      right_q   <= '0;
      pressed_q <= 1'b0;
      park_q    <= 1'b0;
      armed_q   <= 1'b0;
      pulse_q   <= 1'b0;
      elapsed_q <= '0;
    end else if (step_i) begin
      left_q    <= left_d;
      right_q   <= right_d;
      pressed_q <= pressed_d;
      park_q    <= park_d;
      armed_q   <= armed_d;
      pulse_q   <= pulse_d;
      elapsed_q <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire
